@@ rtl/tsm_pkg.sv @@
// Shared types, widths, codes and reset values for the two-wire sensor serial master.
package tsm_pkg;

	localparam int unsigned ADDR_W  = 7;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned PHASE_W = 8;
	localparam int unsigned BIT_W   = 4;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned CDATA_W = 16;

	localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESYNC = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

	localparam logic [CIDX_W-1:0] CFG_LOW_PHASE  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_HIGH_PHASE = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_RSYNC_LOW  = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_RSYNC_WAIT = 2'd3;

	localparam logic [PHASE_W-1:0] LOW_PHASE_RST  = 8'd1;
	localparam logic [PHASE_W-1:0] HIGH_PHASE_RST = 8'd3;
	localparam logic [PHASE_W-1:0] RSYNC_LOW_RST  = 8'd1;
	localparam logic [TICK_W-1:0]  RSYNC_WAIT_RST = 16'd2000;

	typedef struct packed {
		logic [PHASE_W-1:0] low_phase_ticks;
		logic [PHASE_W-1:0] high_phase_ticks;
		logic [PHASE_W-1:0] resync_low_ticks;
		logic [TICK_W-1:0]  resync_wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic              clock_out;
		logic              line_out;
		logic              line_drive;
		logic              busy_res;
		logic              read_valid;
		logic [BYTE_W-1:0] read_byte;
	} res_t;

endpackage

@@ rtl/tsm_in_if.sv @@
// Tick input channel: one beat per timing tick.
interface tsm_in_if import tsm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              start_req;
	logic [MODE_W-1:0] mode;
	logic [ADDR_W-1:0] reg_address;
	logic [BYTE_W-1:0] write_byte;
	logic              line_in;

	modport source(output valid, start_req, mode, reg_address, write_byte, line_in,
		input ready);
	modport sink(input valid, start_req, mode, reg_address, write_byte, line_in,
		output ready);
endinterface

@@ rtl/tsm_out_if.sv @@
// Result channel: one beat of pin levels and read data per tick.
interface tsm_out_if import tsm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              clock_out;
	logic              line_out;
	logic              line_drive;
	logic              busy_res;
	logic              read_valid;
	logic [BYTE_W-1:0] read_byte;

	modport source(output valid, clock_out, line_out, line_drive, busy_res, read_valid,
		read_byte, input ready);
	modport sink(input valid, clock_out, line_out, line_drive, busy_res, read_valid,
		read_byte, output ready);
endinterface

@@ rtl/tsm_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface tsm_cfg_if import tsm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CIDX_W-1:0]  index;
	logic [CDATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/two_wire_sensor_serial_master.sv @@
// Top level of the two-wire sensor serial master: channels, config and result register.
//
// Each beat on in_ch is one timing tick of the serial waveform. When the master is
// idle, a beat with start_req set and mode write, read or resync begins a transfer;
// start_req is ignored while busy or with the unused mode code. Every input beat
// produces exactly one beat on out_ch carrying the clock and data pin levels for that
// tick, the drive enable, the busy flag and, on the last tick of a read, the byte.
// The result appears in the cycle after its input beat is taken, from an output register.
// While out_ch is ready a new tick is taken in every cycle, so throughput is one beat
// per cycle; the output register lets the next tick in while the current result is
// being taken. If out_ch stalls with a result held, in_ch.ready drops and the
// sequencer does not advance, so no tick is lost or repeated.
// Timing registers are written through cfg, which is always ready; they should be
// written only while no transfer is in progress.
// Reset puts the sequencer in idle with the clock high and loads the timing
// registers with 1, 3, 1 and 2000 ticks; no result is pending after reset.
module two_wire_sensor_serial_master import tsm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	tsm_in_if.sink   in_ch,
	tsm_out_if.source out_ch,
	tsm_cfg_if.sink  cfg
);

	cfg_t cfg_val;
	res_t res;
	res_t res_q;
	logic out_valid_q;
	logic step;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign step        = in_ch.valid && in_ch.ready;

	tsm_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid && cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_val)
	);

	tsm_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.cfg         (cfg_val),
		.start_req   (in_ch.start_req),
		.mode        (in_ch.mode),
		.reg_address (in_ch.reg_address),
		.write_byte  (in_ch.write_byte),
		.line_in     (in_ch.line_in),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.clock_out  = res_q.clock_out;
	assign out_ch.line_out   = res_q.line_out;
	assign out_ch.line_drive = res_q.line_drive;
	assign out_ch.busy_res   = res_q.busy_res;
	assign out_ch.read_valid = res_q.read_valid;
	assign out_ch.read_byte  = res_q.read_byte;

endmodule

@@ rtl/tsm_cfg_regs.sv @@
// Configuration register file holding the phase and resync timing values.
module tsm_cfg_regs import tsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [CIDX_W-1:0]  wr_index,
	input  logic [CDATA_W-1:0] wr_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_phase_ticks   <= LOW_PHASE_RST;
			cfg_q.high_phase_ticks  <= HIGH_PHASE_RST;
			cfg_q.resync_low_ticks  <= RSYNC_LOW_RST;
			cfg_q.resync_wait_ticks <= RSYNC_WAIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_LOW_PHASE:  cfg_q.low_phase_ticks   <= wr_data[PHASE_W-1:0];
				CFG_HIGH_PHASE: cfg_q.high_phase_ticks  <= wr_data[PHASE_W-1:0];
				CFG_RSYNC_LOW:  cfg_q.resync_low_ticks  <= wr_data[PHASE_W-1:0];
				CFG_RSYNC_WAIT: cfg_q.resync_wait_ticks <= wr_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/tsm_engine.sv @@
// Transfer sequencer: bit timing, shift registers and the pin levels of one tick.
module tsm_engine import tsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  cfg_t              cfg,
	input  logic              start_req,
	input  logic [MODE_W-1:0] mode,
	input  logic [ADDR_W-1:0] reg_address,
	input  logic [BYTE_W-1:0] write_byte,
	input  logic              line_in,
	output res_t              res
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LOW   = 3'd1,
		PH_HIGH  = 3'd2,
		PH_RLOW  = 3'd3,
		PH_RWAIT = 3'd4
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [BIT_W-1:0]   bit_index_q, bit_index_d;
	logic [TICK_W-1:0]  tick_q, tick_d;
	logic [BYTE_W-1:0]  shift_out_q, shift_out_d;
	logic [BYTE_W-1:0]  shift_in_q, shift_in_d;
	logic [BYTE_W-1:0]  pending_q, pending_d;
	logic               is_read_q, is_read_d;

	always_comb begin
		logic              released;
		logic [TICK_W-1:0] tick_inc;
		logic [BIT_W-1:0]  bit_inc;
		logic [2:0]        bit_sel;

		phase_d     = phase_q;
		bit_index_d = bit_index_q;
		tick_d      = tick_q;
		shift_out_d = shift_out_q;
		shift_in_d  = shift_in_q;
		pending_d   = pending_q;
		is_read_d   = is_read_q;

		res = '0;
		res.clock_out  = 1'b1;
		res.line_drive = 1'b1;

		if (phase_q == PH_IDLE && start_req && mode != MODE_NONE) begin
			tick_d      = '0;
			bit_index_d = '0;
			shift_in_d  = '0;
			if (mode == MODE_RESYNC) begin
				phase_d = PH_RLOW;
			end else begin
				is_read_d   = (mode == MODE_READ);
				shift_out_d = {(mode != MODE_READ), reg_address};
				pending_d   = (mode == MODE_READ) ? '0 : write_byte;
				phase_d     = PH_LOW;
			end
		end

		released = is_read_d && bit_index_d[BIT_W-1];
		tick_inc = tick_d + 1'b1;
		bit_inc  = bit_index_d + 1'b1;
		bit_sel  = ~bit_index_d[2:0];

		unique case (phase_d)
			PH_IDLE: begin
			end
			PH_LOW, PH_HIGH: begin
				res.busy_res   = 1'b1;
				res.clock_out  = (phase_d == PH_HIGH);
				res.line_drive = !released;
				res.line_out   = released ? 1'b0 : shift_out_d[bit_sel];
				if (phase_d == PH_LOW) begin
					tick_d = tick_inc;
					if (tick_inc >= TICK_W'(cfg.low_phase_ticks)) begin
						phase_d = PH_HIGH;
						tick_d  = '0;
					end
				end else begin
					if (released && tick_d == '0) begin
						shift_in_d = {shift_in_d[BYTE_W-2:0], line_in};
					end
					tick_d = tick_inc;
					if (tick_inc >= TICK_W'(cfg.high_phase_ticks)) begin
						tick_d      = '0;
						bit_index_d = bit_inc;
						if (bit_inc == '0) begin
							phase_d = PH_IDLE;
							if (is_read_d) begin
								res.read_valid = 1'b1;
								res.read_byte  = shift_in_d;
							end
						end else begin
							if (bit_inc == BIT_W'(BYTE_W) && !is_read_d) begin
								shift_out_d = pending_d;
							end
							phase_d = PH_LOW;
						end
					end
				end
			end
			PH_RLOW: begin
				res.busy_res  = 1'b1;
				res.clock_out = 1'b0;
				tick_d = tick_inc;
				if (tick_inc >= TICK_W'(cfg.resync_low_ticks)) begin
					phase_d = PH_RWAIT;
					tick_d  = '0;
				end
			end
			PH_RWAIT: begin
				res.busy_res = 1'b1;
				tick_d = tick_inc;
				if (tick_inc >= cfg.resync_wait_ticks) begin
					phase_d = PH_IDLE;
					tick_d  = '0;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_index_q <= '0;
			tick_q      <= '0;
			shift_out_q <= '0;
			shift_in_q  <= '0;
			pending_q   <= '0;
			is_read_q   <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			bit_index_q <= bit_index_d;
			tick_q      <= tick_d;
			shift_out_q <= shift_out_d;
			shift_in_q  <= shift_in_d;
			pending_q   <= pending_d;
			is_read_q   <= is_read_d;
		end
	end

endmodule

@@ tb/tsm_pin_checker.sv @@
// Pin-level checker for the two-wire sensor serial master: predicts and compares every result beat.
`timescale 1ns / 1ps

module tsm_pin_checker import tsm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tsm_in_if    in_mon,
	tsm_out_if   out_mon,
	tsm_cfg_if   cfg_mon,
	output int   error_count,
	output int   outstanding
);

	typedef enum logic [2:0] {SEQ_IDLE, SEQ_LOW, SEQ_HIGH, SEQ_RLOW, SEQ_RWAIT} seq_phase_t;

	cfg_t              timing;
	seq_phase_t        seq_phase;
	logic [BIT_W-1:0]  bit_no;
	logic [TICK_W-1:0] ticks;
	logic [BYTE_W-1:0] tx_shift;
	logic [BYTE_W-1:0] rx_shift;
	logic [BYTE_W-1:0] tx_next;
	logic              rd_xfer;
	res_t              pin_levels_q[$];
	int                mismatches;

	function automatic res_t next_pins(input logic start, input logic [MODE_W-1:0] md,
		input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] wb, input logic lin);
		res_t pins;
		logic released;
		pins = '0;
		pins.clock_out = 1'b1;
		pins.line_drive = 1'b1;
		if (seq_phase == SEQ_IDLE && start && md != MODE_NONE) begin
			ticks = '0;
			bit_no = '0;
			rx_shift = '0;
			if (md == MODE_RESYNC) begin
				seq_phase = SEQ_RLOW;
			end else begin
				rd_xfer = (md == MODE_READ);
				tx_shift = {~rd_xfer, addr};
				tx_next = rd_xfer ? '0 : wb;
				seq_phase = SEQ_LOW;
			end
		end
		case (seq_phase)
			SEQ_LOW, SEQ_HIGH: begin
				released = rd_xfer && bit_no[3];
				pins.busy_res = 1'b1;
				pins.clock_out = (seq_phase == SEQ_HIGH);
				if (released)
					pins.line_drive = 1'b0;
				else
					pins.line_out = tx_shift[3'd7 - bit_no[2:0]];
				if (seq_phase == SEQ_LOW) begin
					ticks = ticks + 1'b1;
					if (ticks >= timing.low_phase_ticks) begin
						seq_phase = SEQ_HIGH;
						ticks = '0;
					end
				end else begin
					// The read line is sampled on the first clock-high tick of each bit of a read's data byte.
					if (released && ticks == '0)
						rx_shift = {rx_shift[BYTE_W-2:0], lin};
					ticks = ticks + 1'b1;
					if (ticks >= timing.high_phase_ticks) begin
						ticks = '0;
						bit_no = bit_no + 1'b1;
						if (bit_no == '0) begin
							seq_phase = SEQ_IDLE;
							pins.read_valid = rd_xfer;
							pins.read_byte = rd_xfer ? rx_shift : '0;
						end else begin
							if (bit_no == 4'd8 && !rd_xfer)
								tx_shift = tx_next;
							seq_phase = SEQ_LOW;
						end
					end
				end
			end
			SEQ_RLOW: begin
				pins.busy_res = 1'b1;
				pins.clock_out = 1'b0;
				ticks = ticks + 1'b1;
				if (ticks >= timing.resync_low_ticks) begin
					seq_phase = SEQ_RWAIT;
					ticks = '0;
				end
			end
			SEQ_RWAIT: begin
				pins.busy_res = 1'b1;
				ticks = ticks + 1'b1;
				if (ticks >= timing.resync_wait_ticks) begin
					seq_phase = SEQ_IDLE;
					ticks = '0;
				end
			end
			default: ;
		endcase
		return pins;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			timing.low_phase_ticks = LOW_PHASE_RST;
			timing.high_phase_ticks = HIGH_PHASE_RST;
			timing.resync_low_ticks = RSYNC_LOW_RST;
			timing.resync_wait_ticks = RSYNC_WAIT_RST;
			seq_phase = SEQ_IDLE;
			bit_no = '0;
			ticks = '0;
			tx_shift = '0;
			rx_shift = '0;
			tx_next = '0;
			rd_xfer = 1'b0;
			pin_levels_q.delete();
			mismatches = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				got.clock_out = out_mon.clock_out;
				got.line_out = out_mon.line_out;
				got.line_drive = out_mon.line_drive;
				got.busy_res = out_mon.busy_res;
				got.read_valid = out_mon.read_valid;
				got.read_byte = out_mon.read_byte;
				if (pin_levels_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result beat with no tick waiting for it", $time);
				end else begin
					want = pin_levels_q.pop_front();
					if (want.clock_out !== got.clock_out || want.line_out !== got.line_out ||
						want.line_drive !== got.line_drive || want.busy_res !== got.busy_res ||
						want.read_valid !== got.read_valid ||
						want.read_byte !== got.read_byte) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: pin mismatch, expected sck %0b sdo %0b oe %0b busy %0b rv %0b byte %02h",
								$time, want.clock_out, want.line_out, want.line_drive,
								want.busy_res, want.read_valid, want.read_byte);
							$display("%0t: pin mismatch, got      sck %0b sdo %0b oe %0b busy %0b rv %0b byte %02h",
								$time, got.clock_out, got.line_out, got.line_drive,
								got.busy_res, got.read_valid, got.read_byte);
						end
					end
				end
			end
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_mon.index)
					CFG_LOW_PHASE: timing.low_phase_ticks = cfg_mon.data[PHASE_W-1:0];
					CFG_HIGH_PHASE: timing.high_phase_ticks = cfg_mon.data[PHASE_W-1:0];
					CFG_RSYNC_LOW: timing.resync_low_ticks = cfg_mon.data[PHASE_W-1:0];
					CFG_RSYNC_WAIT: timing.resync_wait_ticks = cfg_mon.data;
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready)
				pin_levels_q.push_back(next_pins(in_mon.start_req, in_mon.mode,
					in_mon.reg_address, in_mon.write_byte, in_mon.line_in));
		end
		error_count <= mismatches;
		outstanding <= pin_levels_q.size();
	end

endmodule

@@ tb/tb_two_wire_sensor_serial_master.sv @@
// Stimulus and verdict for the two-wire sensor serial master testbench.
`timescale 1ns / 1ps

module tb_two_wire_sensor_serial_master;
	import tsm_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;

	typedef enum int {LINE_RANDOM, LINE_HIGH, LINE_LOW} line_level_t;

	logic        clk;
	logic        arst_n;
	int          cycle_count = 0;
	int          errors;
	int          outstanding;
	bit          idle_on;
	bit          idling_allowed;
	bit          hold_long;
	line_level_t line_level;
	int          eff_low;
	int          eff_high;
	int          eff_rlow;
	int          eff_rwait;

	tsm_in_if  in_ch();
	tsm_out_if out_ch();
	tsm_cfg_if cfg_ch();

	two_wire_sensor_serial_master u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg   (cfg_ch)
	);

	tsm_pin_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.cfg_mon    (cfg_ch),
		.error_count(errors),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_two_wire_sensor_serial_master: errors");
			$finish;
		end
	end

	initial begin : receiver
		int n;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_long) begin
				hold_long = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 19) == 0) begin
				n = $urandom_range(1, 15);
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic push_tick(input logic start, input logic [MODE_W-1:0] md,
		input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] wb);
		int gap;
		if (idle_on && $urandom_range(0, 19) == 0) begin
			gap = $urandom_range(1, 15);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.start_req <= start;
		in_ch.mode <= md;
		in_ch.reg_address <= addr;
		in_ch.write_byte <= wb;
		in_ch.line_in <= (line_level == LINE_RANDOM) ? 1'($urandom_range(0, 1)) :
			(line_level == LINE_HIGH);
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Ticks are sent back to back for the whole length of the transfer, with requests
	// scattered through it that the busy master has to ignore. Gaps come with idle_on.
	task automatic run_xfer(input logic [MODE_W-1:0] md, input logic [ADDR_W-1:0] addr,
		input logic [BYTE_W-1:0] wb, input int gap, input int noise_pct);
		int span;
		case (md)
			MODE_WRITE, MODE_READ: span = 16 * (eff_low + eff_high);
			MODE_RESYNC: span = eff_rlow + eff_rwait;
			default: span = 1;
		endcase
		push_tick(1'b1, md, addr, wb);
		for (int i = 1; i < span; i++)
			push_tick($urandom_range(0, 99) < noise_pct, MODE_W'($urandom_range(0, 3)),
				ADDR_W'($urandom), BYTE_W'($urandom));
		repeat (gap) push_tick(1'b0, MODE_W'($urandom_range(0, 3)), ADDR_W'($urandom),
			BYTE_W'($urandom));
	endtask

	task automatic random_xfers(input int count, input int max_gap);
		int pick;
		logic [MODE_W-1:0] md;
		repeat (count) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				md = MODE_WRITE;
			else if (pick < 8)
				md = MODE_READ;
			else if (pick == 8)
				md = MODE_RESYNC;
			else
				md = MODE_NONE;
			if (idling_allowed)
				idle_on = ($urandom_range(0, 3) != 0);
			run_xfer(md, ADDR_W'($urandom), BYTE_W'($urandom), $urandom_range(0, max_gap), 20);
		end
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic write_timing(input logic [CDATA_W-1:0] lp, input logic [CDATA_W-1:0] hp,
		input logic [CDATA_W-1:0] rl, input logic [CDATA_W-1:0] rw);
		write_reg(CFG_LOW_PHASE, lp);
		write_reg(CFG_HIGH_PHASE, hp);
		write_reg(CFG_RSYNC_LOW, rl);
		write_reg(CFG_RSYNC_WAIT, rw);
		cfg_ch.valid <= 1'b0;
		// A length written as zero behaves as one tick.
		eff_low = (lp[PHASE_W-1:0] == 0) ? 1 : int'(lp[PHASE_W-1:0]);
		eff_high = (hp[PHASE_W-1:0] == 0) ? 1 : int'(hp[PHASE_W-1:0]);
		eff_rlow = (rl[PHASE_W-1:0] == 0) ? 1 : int'(rl[PHASE_W-1:0]);
		eff_rwait = (rw == 0) ? 1 : int'(rw);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		repeat (4) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.start_req <= 1'b0;
		in_ch.mode <= MODE_WRITE;
		in_ch.reg_address <= '0;
		in_ch.write_byte <= '0;
		in_ch.line_in <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_LOW_PHASE;
		cfg_ch.data <= '0;
		idle_on = 1'b1;
		idling_allowed = 1'b1;
		hold_long = 1'b0;
		line_level = LINE_RANDOM;
		eff_low = int'(LOW_PHASE_RST);
		eff_high = int'(HIGH_PHASE_RST);
		eff_rlow = int'(RSYNC_LOW_RST);
		eff_rwait = int'(RSYNC_WAIT_RST);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		repeat (2) push_tick(1'b0, MODE_WRITE, '0, '0);
		line_level = LINE_HIGH;
		run_xfer(MODE_WRITE, 7'h7F, 8'hFF, 0, 0);
		run_xfer(MODE_READ, 7'h7F, 8'h00, 0, 0);
		drain();

		write_timing(16'd1, 16'd1, 16'd1, 16'd1);
		run_xfer(MODE_WRITE, 7'h00, 8'h00, 1, 0);
		line_level = LINE_LOW;
		run_xfer(MODE_READ, 7'h00, 8'hFF, 2, 100);
		line_level = LINE_RANDOM;
		run_xfer(MODE_NONE, 7'h2A, 8'h5A, 2, 0);
		run_xfer(MODE_RESYNC, 7'h7F, 8'hFF, 1, 100);
		run_xfer(MODE_READ, 7'h55, 8'hA5, 0, 0);
		drain();

		write_timing(16'h0000, 16'hFF00, 16'h0100, 16'h0000);
		random_xfers(2, 3);
		drain();

		write_timing(CDATA_W'($urandom_range(1, 2)), CDATA_W'($urandom_range(1, 2)),
			CDATA_W'($urandom_range(1, 3)), CDATA_W'($urandom_range(1, 8)));
		hold_long = 1'b1;
		random_xfers(3, 3);
		drain();

		idling_allowed = 1'b0;
		idle_on = 1'b0;
		write_timing(16'd2, 16'd1, 16'd3, 16'd5);
		random_xfers(1, 1);
		drain();

		repeat (8) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("tb_two_wire_sensor_serial_master: clean");
		else
			$display("tb_two_wire_sensor_serial_master: errors");
		$finish;
	end

endmodule
